// ===== rtl/rist_pkg.sv =====
// ----------------------------------------------------------------------------
// rist_pkg
// Shared types and constants for the raster interrupt sequencer and its
// frame clock.
// ----------------------------------------------------------------------------
package rist_pkg;

    localparam int LINE_W   = 9;
    localparam int FIRED_W  = 3;
    localparam int MILLI_W  = 10;
    localparam int COUNT_W  = 16;
    localparam int MODE_W   = 2;

    localparam logic [LINE_W-1:0] PAL_LINES  = 9'd312;
    localparam logic [LINE_W-1:0] NTSC_LINES = 9'd262;

    localparam logic [4:0] PAL_FRAME_MS  = 5'd20;
    localparam logic [4:0] NTSC_FRAME_MS = 5'd16;

    localparam logic [MILLI_W:0]   NTSC_ERROR_STEP = 11'd667;
    localparam logic [MILLI_W:0]   ERROR_LIMIT     = 11'd1000;
    localparam logic [MILLI_W-1:0] MILLIS_PER_SEC  = 10'd1000;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_STEP = 2'd0,
        MODE_RASTER   = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_ARM      = 2'd3
    } mode_t;

    typedef struct packed {
        logic              handler;
        logic [LINE_W-1:0] line;
    } step_entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] frames;
        logic [COUNT_W-1:0] seconds;
        logic [MILLI_W-1:0] millis;
    } clock_t;

endpackage

// ===== rtl/raster_irq_sequencer_frame_clock_core.sv =====
// ----------------------------------------------------------------------------
// raster_irq_sequencer_frame_clock_core
// Raster interrupt step sequencer with a frame clock.
//
// Input transactions carry one command (add step, raster event, clear, arm)
// on a valid/ready channel. Every command produces exactly one output
// transaction carrying the compare line, the fired step, the handler flag,
// the vertical blank flag and the frame clock after the command.
// The step table sits in a synchronous memory. A command is accepted while
// the sequencer is idle, and the table is read in that cycle; it is committed
// from the execute state, when the state is updated and the result is loaded
// into the output register. The table read is registered before the update,
// and no new command is accepted until the last one has committed.
// When the receiver stalls, the finished command waits in the commit stage
// until the output register frees, and no new command is accepted.
// The is_pal_reg register is written through cfg_write_en; the user must write it
// only while idle, as the block does not enforce it. Reset empties the table,
// clears the counters, selects PAL and leaves the output channel empty.
// ----------------------------------------------------------------------------
module raster_irq_sequencer_frame_clock_core #(
    parameter int MAX_STEPS     = 8,
    parameter int BOTTOM_MARGIN = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic                          cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rist_pkg::MODE_W-1:0]   mode,
    input  logic [rist_pkg::LINE_W-1:0]   line,
    input  logic                          use_bottom_line,
    input  logic                          has_handler,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rist_pkg::LINE_W-1:0]   compare_line,
    output logic [rist_pkg::FIRED_W-1:0]  fired_step,
    output logic                          run_handler,
    output logic                          vertical_blank,
    output logic [rist_pkg::COUNT_W-1:0]  frame_count,
    output logic [rist_pkg::COUNT_W-1:0]  seconds,
    output logic [rist_pkg::MILLI_W-1:0]  millis,
    output logic                          step_accepted
);
    import rist_pkg::*;

    localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CNT_W = (MAX_STEPS > 2) ? $clog2(MAX_STEPS + 1) : 2;
    localparam logic [CNT_W-1:0]  TOTAL_MAX = CNT_W'(MAX_STEPS);
    localparam logic [CNT_W-1:0]  TOTAL_TWO = CNT_W'(2);
    localparam logic [LINE_W-1:0] MARGIN    = LINE_W'(BOTTOM_MARGIN);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t             state_reg;
    logic               is_pal_reg;
    logic [CNT_W-1:0]   step_total_reg;
    logic [CNT_W-1:0]   step_total_next;
    logic [IDX_W-1:0]   step_now_reg;
    logic [IDX_W-1:0]   step_now_next;
    logic [LINE_W-1:0]  irq_compare_reg;
    logic [LINE_W-1:0]  irq_compare_next;

    mode_t              cmd_mode_reg;
    logic [LINE_W-1:0]  cmd_line_reg;
    logic               cmd_bottom_reg;
    logic               cmd_handler_reg;

    logic               out_valid_reg;
    logic [LINE_W-1:0]  compare_line_reg;
    logic [FIRED_W-1:0] fired_step_reg;
    logic               run_handler_reg;
    logic               vertical_blank_reg;
    clock_t             clock_out_reg;
    logic               step_accepted_reg;

    logic               accept;
    logic               commit;
    logic [CNT_W-1:0]   step_inc;
    logic               step_wrap;
    logic [IDX_W-1:0]   next_idx;
    logic [IDX_W-1:0]   raddr_a;
    logic [LINE_W-1:0]  frame_lines;
    logic [LINE_W-1:0]  add_line;
    logic               table_full;
    logic               frame_done;
    logic               run_next;
    logic               accepted_next;
    logic [IDX_W+FIRED_W-1:0] fired_wide;

    logic               mem_we;
    step_entry_t        mem_wdata;
    step_entry_t        rdata_a;
    step_entry_t        rdata_b;
    clock_t             clock_next;

    assign accept   = in_valid && in_ready;
    assign in_ready = state_reg == ST_IDLE;
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        step_inc    = {{(CNT_W-IDX_W){1'b0}}, step_now_reg} + {{(CNT_W-1){1'b0}}, 1'b1};
        step_wrap   = step_inc >= step_total_reg;
        next_idx    = step_wrap ? '0 : step_inc[IDX_W-1:0];
        raddr_a     = (mode_t'(mode) == MODE_ARM) ? '0 : step_now_reg;
        frame_lines = is_pal_reg ? PAL_LINES : NTSC_LINES;
        add_line    = cmd_bottom_reg ? (frame_lines - MARGIN) : cmd_line_reg;
        table_full  = step_total_reg >= TOTAL_MAX;
        fired_wide  = {{FIRED_W{1'b0}}, step_now_reg};
    end

    always_comb
    begin
        step_total_next  = step_total_reg;
        step_now_next    = step_now_reg;
        irq_compare_next = irq_compare_reg;
        frame_done       = 1'b0;
        run_next         = 1'b0;
        accepted_next    = 1'b0;
        mem_we           = 1'b0;
        mem_wdata.handler = cmd_handler_reg;
        mem_wdata.line    = add_line;
        unique case (cmd_mode_reg)
            MODE_ADD_STEP:
            begin
                if (!table_full)
                begin
                    mem_we          = commit;
                    step_total_next = step_total_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                    accepted_next   = 1'b1;
                    if (step_total_reg == '0)
                    begin
                        irq_compare_next = add_line;
                    end
                end
            end
            MODE_RASTER:
            begin
                run_next = ({{(CNT_W-IDX_W){1'b0}}, step_now_reg} < step_total_reg)
                           && rdata_a.handler;
                if (step_total_reg < TOTAL_TWO)
                begin
                    frame_done = 1'b1;
                end
                else
                begin
                    frame_done       = step_wrap;
                    step_now_next    = next_idx;
                    irq_compare_next = rdata_b.line;
                end
            end
            MODE_CLEAR:
            begin
                step_total_next = '0;
                step_now_next   = '0;
            end
            MODE_ARM:
            begin
                if (step_total_reg != '0)
                begin
                    irq_compare_next = rdata_a.line;
                end
                else
                begin
                    irq_compare_next = frame_lines - {{(LINE_W-1){1'b0}}, 1'b1};
                end
            end
            default:
            begin
                step_total_next = step_total_reg;
            end
        endcase
    end

    rist_step_mem #(
        .DEPTH (MAX_STEPS),
        .IDX_W (IDX_W)
    ) u_step_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (step_total_reg[IDX_W-1:0]),
        .wdata   (mem_wdata),
        .re      (accept),
        .raddr_a (raddr_a),
        .raddr_b (next_idx),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    rist_frame_clock u_frame_clock (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (commit && frame_done),
        .is_pal   (is_pal_reg),
        .cnt_next (clock_next)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_mode_reg    <= mode_t'(mode);
            cmd_line_reg    <= line;
            cmd_bottom_reg  <= use_bottom_line;
            cmd_handler_reg <= has_handler;
        end
        if (commit)
        begin
            compare_line_reg   <= irq_compare_next;
            fired_step_reg     <= (cmd_mode_reg == MODE_RASTER) ? fired_wide[FIRED_W-1:0] : '0;
            run_handler_reg    <= run_next;
            vertical_blank_reg <= frame_done;
            clock_out_reg      <= clock_next;
            step_accepted_reg  <= accepted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            is_pal_reg      <= 1'b1;
            step_total_reg  <= '0;
            step_now_reg    <= '0;
            irq_compare_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                is_pal_reg <= cfg_write_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (commit)
            begin
                step_total_reg  <= step_total_next;
                step_now_reg    <= step_now_next;
                irq_compare_reg <= irq_compare_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign compare_line   = compare_line_reg;
    assign fired_step     = fired_step_reg;
    assign run_handler    = run_handler_reg;
    assign vertical_blank = vertical_blank_reg;
    assign frame_count    = clock_out_reg.frames;
    assign seconds        = clock_out_reg.seconds;
    assign millis         = clock_out_reg.millis;
    assign step_accepted  = step_accepted_reg;

    a_write_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> commit && (cmd_mode_reg == MODE_ADD_STEP))
        else $error("Step table written outside an add step commit.");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_total_reg <= TOTAL_MAX)
        else $error("Step count exceeds the table depth.");

    a_pointer_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        ({{(CNT_W-IDX_W){1'b0}}, step_now_reg} < step_total_reg) || (step_now_reg == '0))
        else $error("Step pointer outside the stored steps.");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("Committed transaction did not reach the output register.");

endmodule

// ===== rtl/rist_step_mem.sv =====
// ----------------------------------------------------------------------------
// rist_step_mem
// Step table: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rist_step_mem #(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  rist_pkg::step_entry_t wdata,
    input  logic                 re,
    input  logic [IDX_W-1:0]     raddr_a,
    input  logic [IDX_W-1:0]     raddr_b,
    output rist_pkg::step_entry_t rdata_a,
    output rist_pkg::step_entry_t rdata_b
);
    import rist_pkg::*;

    step_entry_t mem [DEPTH];
    step_entry_t rdata_a_reg;
    step_entry_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/rist_frame_clock.sv =====
// ----------------------------------------------------------------------------
// rist_frame_clock
// Millisecond, second and frame counters advanced once per completed frame,
// with the NTSC fractional millisecond carried in an error accumulator.
// ----------------------------------------------------------------------------
module rist_frame_clock (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            is_pal,
    output rist_pkg::clock_t cnt_next
);
    import rist_pkg::*;

    logic [MILLI_W-1:0] micro_error_reg;
    logic [MILLI_W-1:0] micro_error_next;
    clock_t             cnt_reg;
    clock_t             cnt_adv;

    logic [MILLI_W:0]   err_sum;
    logic               err_carry;
    logic [MILLI_W:0]   err_wrapped;
    logic [4:0]         delta;
    logic [MILLI_W-1:0] milli_sum;
    logic               milli_roll;

    always_comb
    begin
        err_sum     = {1'b0, micro_error_reg} + NTSC_ERROR_STEP;
        err_carry   = err_sum >= ERROR_LIMIT;
        err_wrapped = err_carry ? (err_sum - ERROR_LIMIT) : err_sum;
        if (is_pal)
        begin
            delta = PAL_FRAME_MS;
        end
        else
        begin
            delta = NTSC_FRAME_MS + {4'd0, err_carry};
        end
        milli_sum  = cnt_reg.millis + {{(MILLI_W-5){1'b0}}, delta};
        milli_roll = milli_sum >= MILLIS_PER_SEC;

        cnt_adv.frames  = cnt_reg.frames + 16'd1;
        cnt_adv.seconds = milli_roll ? (cnt_reg.seconds + 16'd1) : cnt_reg.seconds;
        cnt_adv.millis  = milli_roll ? (milli_sum - MILLIS_PER_SEC) : milli_sum;

        micro_error_next = micro_error_reg;
        if (advance && !is_pal)
        begin
            micro_error_next = err_wrapped[MILLI_W-1:0];
        end
        cnt_next = advance ? cnt_adv : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            micro_error_reg <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            micro_error_reg <= micro_error_next;
            cnt_reg         <= cnt_next;
        end
    end

    a_millis_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg.millis < MILLIS_PER_SEC)
        else $error("Millisecond count left its range.");

    a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, micro_error_reg} < ERROR_LIMIT)
        else $error("Error accumulator left its range.");

    a_frames_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> cnt_reg.frames == $past(cnt_reg.frames) + 16'd1)
        else $error("Frame count did not advance on a completed frame.");

endmodule
